// ===== src/swsr_pkg.sv =====
`timescale 1ns / 1ps

package swsr_pkg;

    // Transaction phases of the reader
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_START    = 3'd1,
        PH_RESP     = 3'd2,
        PH_ACKH     = 3'd3,
        PH_ACKFALL  = 3'd4,
        PH_BITHIGH  = 3'd5,
        PH_BITDELAY = 3'd6
    } phase_t;

    // Event codes reported with each result
    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_NO_RESPONSE = 3'd1,
        EV_BAD_ACK     = 3'd2,
        EV_ACK_GOOD    = 3'd3,
        EV_BYTE_READY  = 3'd4
    } event_t;

    // Configuration register indexes
    localparam logic [2:0] REG_START_LOW_TIME  = 3'd0;
    localparam logic [2:0] REG_RESPONSE_WAIT   = 3'd1;
    localparam logic [2:0] REG_ACK_HIGH_WAIT   = 3'd2;
    localparam logic [2:0] REG_BIT_SAMPLE_TIME = 3'd3;
    localparam logic [2:0] REG_BYTES_PER_READ  = 3'd4;

    // Register reset values
    localparam logic [15:0] START_LOW_TIME_RST  = 16'd18000;
    localparam logic [7:0]  RESPONSE_WAIT_RST   = 8'd40;
    localparam logic [7:0]  ACK_HIGH_WAIT_RST   = 8'd90;
    localparam logic [7:0]  BIT_SAMPLE_TIME_RST = 8'd40;
    localparam logic [3:0]  BYTES_PER_READ_RST  = 4'd5;

    // Largest number of bytes in one read
    localparam logic [3:0]  MAX_BYTES = 4'd8;

endpackage

// ===== src/single_wire_sensor_reader.sv =====
`timescale 1ns / 1ps

// Host side of a single-wire humidity and temperature sensor link.
// Input stream: one request per clock-enabled step, carrying a start
// request, a one-microsecond tick and the sampled data line level.
// Output stream: one result per request, carrying the line drive, the
// busy flag, an event code (none, no response, bad acknowledge, good
// acknowledge, byte ready) and the decoded byte, with tlast on the final
// byte of a read.
// The result is registered, in the cycle after its request; one request is taken
// every cycle unless stalled, as the sequencer and wait counter settle in one pass.
// A stalled result sits in the output register; a new request is taken in
// the same cycle the held result leaves, so tready drops only while a
// result waits unclaimed.
// The user must write registers (cfg_wr_en / cfg_index / cfg_data) only while the
// block is idle; the block does not enforce it. Reset returns the block to idle
// with the default timings (18000 us start pulse, 40 us / 90 us acknowledge
// checks, 40 us bit sample point, 5 bytes per read) and an empty output register.
module single_wire_sensor_reader
    import swsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] start_request, [1] tick, [2] line_level
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] drive_low, [8:1] data_byte, [9] busy_res
    output logic [2:0]  m_axis_tuser,   // [2:0] event_code
    output logic        m_axis_tlast    // last_byte
);

    logic [15:0] start_low_time_reg;
    logic [7:0]  response_wait_reg;
    logic [7:0]  ack_high_wait_reg;
    logic [7:0]  bit_sample_time_reg;
    logic [3:0]  bytes_per_read_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] wait_counter_reg, wait_counter_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [3:0]  byte_count_reg, byte_count_next;

    logic        out_valid_reg;
    logic        drive_low_reg, busy_reg, last_reg;
    event_t      event_reg, event_next;
    logic [7:0]  data_reg, data_next;
    logic        last_next;

    logic        in_accept;
    logic        start_request, tick, line_level;
    logic        timed;
    logic [15:0] wait_inc;
    logic [7:0]  shift_in;
    logic [3:0]  byte_count_inc;
    logic [3:0]  byte_target;

    assign start_request = s_axis_tdata[0];
    assign tick          = s_axis_tdata[1];
    assign line_level    = s_axis_tdata[2];

    // Take a request whenever the output register is free or being emptied
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_low_time_reg  <= START_LOW_TIME_RST;
            response_wait_reg   <= RESPONSE_WAIT_RST;
            ack_high_wait_reg   <= ACK_HIGH_WAIT_RST;
            bit_sample_time_reg <= BIT_SAMPLE_TIME_RST;
            bytes_per_read_reg  <= BYTES_PER_READ_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_START_LOW_TIME:  start_low_time_reg  <= cfg_data;
                REG_RESPONSE_WAIT:   response_wait_reg   <= cfg_data[7:0];
                REG_ACK_HIGH_WAIT:   ack_high_wait_reg   <= cfg_data[7:0];
                REG_BIT_SAMPLE_TIME: bit_sample_time_reg <= cfg_data[7:0];
                REG_BYTES_PER_READ:  bytes_per_read_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Clamp the byte count to 1..8
    always_comb
    begin
        if (bytes_per_read_reg == 4'd0)
            byte_target = 4'd1;
        else if (bytes_per_read_reg > MAX_BYTES)
            byte_target = MAX_BYTES;
        else
            byte_target = bytes_per_read_reg;
    end

    // Advance the wait counter on ticks in timed phases, saturating
    assign timed = (phase_reg == PH_START) || (phase_reg == PH_RESP) ||
                   (phase_reg == PH_ACKH) || (phase_reg == PH_BITDELAY);
    assign wait_inc = (timed && tick && wait_counter_reg != 16'hFFFF)
                    ? wait_counter_reg + 16'd1 : wait_counter_reg;

    assign shift_in       = {shift_byte_reg[6:0], line_level};
    assign byte_count_inc = byte_count_reg + 4'd1;

    // Next phase, counters and event for the current request
    always_comb
    begin
        phase_next        = phase_reg;
        wait_counter_next = wait_inc;
        bit_index_next    = bit_index_reg;
        shift_byte_next   = shift_byte_reg;
        byte_count_next   = byte_count_reg;
        event_next        = EV_NONE;
        data_next         = 8'd0;
        last_next         = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (start_request)
                begin
                    bit_index_next    = 3'd0;
                    shift_byte_next   = 8'd0;
                    byte_count_next   = 4'd0;
                    phase_next        = PH_START;
                    wait_counter_next = 16'd0;
                end
            end
            PH_START:
            begin
                if (wait_inc >= start_low_time_reg)
                begin
                    phase_next        = PH_RESP;
                    wait_counter_next = 16'd0;
                end
            end
            PH_RESP:
            begin
                if (wait_inc >= {8'd0, response_wait_reg})
                begin
                    wait_counter_next = 16'd0;
                    if (!line_level)
                        phase_next = PH_ACKH;
                    else
                    begin
                        event_next = EV_NO_RESPONSE;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_ACKH:
            begin
                if (wait_inc >= {8'd0, ack_high_wait_reg})
                begin
                    wait_counter_next = 16'd0;
                    if (line_level)
                    begin
                        event_next = EV_ACK_GOOD;
                        phase_next = PH_ACKFALL;
                    end
                    else
                    begin
                        event_next = EV_BAD_ACK;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_ACKFALL:
            begin
                if (!line_level)
                begin
                    phase_next        = PH_BITHIGH;
                    wait_counter_next = 16'd0;
                end
            end
            PH_BITHIGH:
            begin
                if (line_level)
                begin
                    phase_next        = PH_BITDELAY;
                    wait_counter_next = 16'd0;
                end
            end
            PH_BITDELAY:
            begin
                if (wait_inc >= {8'd0, bit_sample_time_reg})
                begin
                    shift_byte_next   = shift_in;
                    wait_counter_next = 16'd0;
                    phase_next        = PH_ACKFALL;
                    if (bit_index_reg == 3'd7)
                    begin
                        bit_index_next  = 3'd0;
                        byte_count_next = byte_count_inc;
                        event_next      = EV_BYTE_READY;
                        data_next       = shift_in;
                        if (byte_count_inc >= byte_target)
                        begin
                            last_next  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                        bit_index_next = bit_index_reg + 3'd1;
                end
            end
            default:
            begin
                phase_next        = PH_IDLE;
                wait_counter_next = 16'd0;
            end
        endcase
    end

    // Update sequencer state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            wait_counter_reg <= 16'd0;
            bit_index_reg    <= 3'd0;
            shift_byte_reg   <= 8'd0;
            byte_count_reg   <= 4'd0;
        end
        else if (in_accept)
        begin
            phase_reg        <= phase_next;
            wait_counter_reg <= wait_counter_next;
            bit_index_reg    <= bit_index_next;
            shift_byte_reg   <= shift_byte_next;
            byte_count_reg   <= byte_count_next;
        end
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            drive_low_reg <= (phase_next == PH_START);
            busy_reg      <= (phase_next != PH_IDLE);
            event_reg     <= event_next;
            data_reg      <= data_next;
            last_reg      <= last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, busy_reg, data_reg, drive_low_reg};
    assign m_axis_tuser  = event_reg;
    assign m_axis_tlast  = last_reg;

    // The final-byte mark comes only with a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == EV_BYTE_READY)
        else $error("last byte mark without a byte");

    // Driving the line low only happens inside a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[9])
        else $error("line driven low while not busy");

    // Untimed phases always start with a cleared wait counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE || phase_reg == PH_ACKFALL || phase_reg == PH_BITHIGH)
        |-> wait_counter_reg == 16'd0)
        else $error("wait counter not cleared in an untimed phase");

    // A partial byte exists only during a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg != 3'd0 |-> phase_reg != PH_IDLE)
        else $error("bit index left nonzero in idle");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import swsr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_STEPS = 150;
    localparam int HOLD_OFF_CYCLES = 300;

    // One result as seen on the output stream
    typedef struct packed {
        logic       drive;
        event_t     ev;
        logic [7:0] dat;
        logic       lst;
        logic       bsy;
    } reading_t;

    // One directed request, with a hand-written result where typed is set
    typedef struct packed {
        logic     st;
        logic     tk;
        logic     lv;
        logic     typed;
        reading_t want;
    } step_row_t;

    localparam reading_t R_IDLE    = '{1'b0, EV_NONE, 8'h00, 1'b0, 1'b0};
    localparam reading_t R_PULL    = '{1'b1, EV_NONE, 8'h00, 1'b0, 1'b1};
    localparam reading_t R_BUSY    = '{1'b0, EV_NONE, 8'h00, 1'b0, 1'b1};
    localparam reading_t R_NO_RESP = '{1'b0, EV_NO_RESPONSE, 8'h00, 1'b0, 1'b0};
    localparam reading_t R_BAD_ACK = '{1'b0, EV_BAD_ACK, 8'h00, 1'b0, 1'b0};
    localparam reading_t R_ACK_OK  = '{1'b0, EV_ACK_GOOD, 8'h00, 1'b0, 1'b1};
    localparam reading_t R_LAST_FF = '{1'b0, EV_BYTE_READY, 8'hFF, 1'b1, 1'b0};

    // Directed walk with one-tick waits, a zero sample delay and a zero byte
    // count (read as one byte): no response, bad acknowledge, then a full
    // read of one all-ones byte sampled without ticks.
    localparam step_row_t DIRECTED_ROWS [39] = '{
        '{1'b0, 1'b0, 1'b0, 1'b1, R_IDLE},
        '{1'b0, 1'b1, 1'b1, 1'b1, R_IDLE},
        '{1'b1, 1'b1, 1'b1, 1'b1, R_PULL},
        '{1'b1, 1'b0, 1'b0, 1'b1, R_PULL},
        '{1'b0, 1'b1, 1'b0, 1'b1, R_BUSY},
        '{1'b0, 1'b1, 1'b1, 1'b1, R_NO_RESP},
        '{1'b1, 1'b0, 1'b0, 1'b1, R_PULL},
        '{1'b0, 1'b1, 1'b0, 1'b1, R_BUSY},
        '{1'b0, 1'b0, 1'b0, 1'b0, R_IDLE},
        '{1'b0, 1'b1, 1'b0, 1'b0, R_IDLE},
        '{1'b0, 1'b1, 1'b0, 1'b1, R_BAD_ACK},
        '{1'b1, 1'b1, 1'b0, 1'b1, R_PULL},
        '{1'b0, 1'b1, 1'b0, 1'b0, R_IDLE},
        '{1'b0, 1'b1, 1'b0, 1'b0, R_IDLE},
        '{1'b0, 1'b1, 1'b1, 1'b1, R_ACK_OK},
        '{1'b0, 1'b0, 1'b0, 1'b0, R_IDLE}, '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, R_IDLE}, '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, R_IDLE}, '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, R_IDLE}, '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, R_IDLE}, '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, R_IDLE}, '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, R_IDLE}, '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, R_IDLE}, '{1'b0, 1'b0, 1'b1, 1'b0, R_IDLE},
        '{1'b0, 1'b0, 1'b1, 1'b1, R_LAST_FF}
    };

    // Idling per random phase: none, sender only, receiver only, both light
    localparam int SRC_IDLE [4]   = '{0, 83, 0, 8};
    localparam int SINK_STALL [4] = '{0, 0, 83, 8};
    localparam int READ_LEN [4]   = '{8, 1, 3, 6};

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] start_request, [1] tick, [2] line_level
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [0] drive_low, [8:1] data_byte, [9] busy_res
    logic [2:0]  m_axis_tuser;   // [2:0] event_code
    logic        m_axis_tlast;

    // Reader model: timing registers and transaction state
    logic [15:0] start_low_us;
    logic [7:0]  resp_wait_us;
    logic [7:0]  ackh_wait_us;
    logic [7:0]  sample_us;
    logic [3:0]  read_len;
    phase_t      rd_phase;
    logic [15:0] rd_wait;
    logic [2:0]  rd_bit;
    logic [7:0]  rd_shift;
    logic [3:0]  rd_count;

    reading_t pending_readings[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       src_idle_pct = 0;
    int       sink_stall_pct = 0;
    int       hold_left = 0;
    int       tick_pct = 100;
    int       noise_pct = 0;

    single_wire_sensor_reader u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void reset_reader();
        start_low_us = START_LOW_TIME_RST;
        resp_wait_us = RESPONSE_WAIT_RST;
        ackh_wait_us = ACK_HIGH_WAIT_RST;
        sample_us    = BIT_SAMPLE_TIME_RST;
        read_len     = BYTES_PER_READ_RST;
        rd_phase     = PH_IDLE;
        rd_wait      = '0;
        rd_bit       = '0;
        rd_shift     = '0;
        rd_count     = '0;
    endfunction

    function automatic void enter_phase(input phase_t p);
        rd_phase = p;
        rd_wait  = '0;
    endfunction

    // Advance the reader by one request and return the result it shows
    function automatic reading_t advance_reader(input logic st, input logic tk,
                                                input logic lv);
        reading_t   r;
        logic [3:0] target;
        r = R_IDLE;
        if (read_len == 4'd0)
            target = 4'd1;
        else if (read_len > MAX_BYTES)
            target = MAX_BYTES;
        else
            target = read_len;

        // Count ticks in the timed phases, saturating
        if ((rd_phase == PH_START || rd_phase == PH_RESP || rd_phase == PH_ACKH ||
             rd_phase == PH_BITDELAY) && tk && rd_wait != 16'hFFFF)
            rd_wait = rd_wait + 16'd1;

        case (rd_phase)
            PH_IDLE:
                if (st)
                begin
                    rd_bit   = '0;
                    rd_shift = '0;
                    rd_count = '0;
                    enter_phase(PH_START);
                end
            PH_START:
                if (rd_wait >= start_low_us)
                    enter_phase(PH_RESP);
            PH_RESP:
                if (rd_wait >= {8'd0, resp_wait_us})
                begin
                    if (!lv)
                        enter_phase(PH_ACKH);
                    else
                    begin
                        r.ev = EV_NO_RESPONSE;
                        enter_phase(PH_IDLE);
                    end
                end
            PH_ACKH:
                if (rd_wait >= {8'd0, ackh_wait_us})
                begin
                    if (lv)
                    begin
                        r.ev = EV_ACK_GOOD;
                        enter_phase(PH_ACKFALL);
                    end
                    else
                    begin
                        r.ev = EV_BAD_ACK;
                        enter_phase(PH_IDLE);
                    end
                end
            PH_ACKFALL:
                if (!lv)
                    enter_phase(PH_BITHIGH);
            PH_BITHIGH:
                if (lv)
                    enter_phase(PH_BITDELAY);
            PH_BITDELAY:
                if (rd_wait >= {8'd0, sample_us})
                begin
                    // Shift in MSB first; emit on the eighth bit
                    rd_shift = {rd_shift[6:0], lv};
                    if (rd_bit == 3'd7)
                    begin
                        rd_bit   = '0;
                        rd_count = rd_count + 4'd1;
                        r.ev     = EV_BYTE_READY;
                        r.dat    = rd_shift;
                        if (rd_count >= target)
                        begin
                            r.lst = 1'b1;
                            enter_phase(PH_IDLE);
                        end
                        else
                            enter_phase(PH_ACKFALL);
                    end
                    else
                    begin
                        rd_bit = rd_bit + 3'd1;
                        enter_phase(PH_ACKFALL);
                    end
                end
            default:
                enter_phase(PH_IDLE);
        endcase

        r.drive = (rd_phase == PH_START);
        r.bsy   = (rd_phase != PH_IDLE);
        return r;
    endfunction

    function automatic void flag_mismatch(input string what, input reading_t want,
                                          input reading_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t: %s: want drive=%0b ev=%0d byte=%02h last=%0b busy=%0b",
                     $realtime, what, want.drive, want.ev, want.dat, want.lst,
                     want.bsy);
            $display("    got drive=%0b ev=%0d byte=%02h last=%0b busy=%0b",
                     got.drive, got.ev, got.dat, got.lst, got.bsy);
        end
    endfunction

    // Offer one request, with random idling ahead of it; predict on accept
    task automatic send_sample(input logic st, input logic tk, input logic lv,
                               input logic typed, input reading_t want);
        reading_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b00000, lv, tk, st};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = advance_reader(st, tk, lv);
        pending_readings.push_back(typed ? want : r);
    endtask

    // Write one register once the reader has gone quiet
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_START_LOW_TIME:  start_low_us = val;
            REG_RESPONSE_WAIT:   resp_wait_us = val[7:0];
            REG_ACK_HIGH_WAIT:   ackh_wait_us = val[7:0];
            REG_BIT_SAMPLE_TIME: sample_us    = val[7:0];
            REG_BYTES_PER_READ:  read_len     = val[3:0];
            default: ;
        endcase
    endtask

    task automatic apply_timing(input logic [15:0] low, input logic [7:0] resp,
                                input logic [7:0] ackh, input logic [7:0] smp,
                                input logic [3:0] len);
        write_reg(REG_START_LOW_TIME, low);
        write_reg(REG_RESPONSE_WAIT, {8'h00, resp});
        write_reg(REG_ACK_HIGH_WAIT, {8'h00, ackh});
        write_reg(REG_BIT_SAMPLE_TIME, {8'h00, smp});
        write_reg(REG_BYTES_PER_READ, {12'h000, len});
    endtask

    // Play the sensor: mostly a well-behaved line, with some stray levels
    task automatic sensor_step();
        logic st;
        logic tk;
        logic lv;
        logic clean;
        clean = ($urandom_range(0, 99) >= noise_pct);
        st = 1'b0;
        tk = ($urandom_range(0, 99) < tick_pct);
        lv = 1'($urandom_range(0, 1));
        case (rd_phase)
            PH_IDLE:    st = ($urandom_range(0, 99) < 70);
            PH_RESP:    if (clean) lv = 1'b0;
            PH_ACKH:    if (clean) lv = 1'b1;
            PH_ACKFALL: if (clean) lv = 1'b0;
            PH_BITHIGH: if (clean) lv = 1'b1;
            default: ;
        endcase
        if (!clean)
        begin
            st = 1'($urandom_range(0, 1));
            tk = 1'($urandom_range(0, 1));
        end
        send_sample(st, tk, lv, 1'b0, R_IDLE);
    endtask

    // Start a read and run it to the end; hold off the receiver at step hold_at
    task automatic run_one_read(input int hold_at);
        int n;
        n = 0;
        do
            sensor_step();
        while (rd_phase == PH_IDLE);
        while (rd_phase != PH_IDLE)
        begin
            sensor_step();
            n++;
            if (n == hold_at)
                hold_left = HOLD_OFF_CYCLES;
        end
    endtask

    // Steer whatever read is open back to idle by the shortest path
    task automatic finish_read();
        logic tk;
        logic lv;
        while (rd_phase != PH_IDLE)
        begin
            tk = 1'b1;
            lv = 1'($urandom_range(0, 1));
            case (rd_phase)
                PH_RESP:    lv = 1'b1;
                PH_ACKH:    lv = 1'b0;
                PH_ACKFALL: begin tk = 1'b0; lv = 1'b0; end
                PH_BITHIGH: begin tk = 1'b0; lv = 1'b1; end
                default: ;
            endcase
            send_sample(1'b0, tk, lv, 1'b0, R_IDLE);
        end
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        reading_t got;
        reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.drive = m_axis_tdata[0];
            got.ev    = event_t'(m_axis_tuser);
            got.dat   = m_axis_tdata[8:1];
            got.lst   = m_axis_tlast;
            got.bsy   = m_axis_tdata[9];
            if (pending_readings.size() == 0)
                flag_mismatch("result with nothing pending", R_IDLE, got);
            else
            begin
                want = pending_readings.pop_front();
                if (got.drive !== want.drive || got.ev !== want.ev ||
                    got.dat !== want.dat || got.lst !== want.lst ||
                    got.bsy !== want.bsy)
                    flag_mismatch("wrong result", want, got);
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int ph;
        int r;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_START_LOW_TIME;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        rst_n         = 1'b0;
        reset_reader();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Full two-byte read at short timings, receiver held off partway through
        apply_timing(16'd4, 8'd2, 8'd2, 8'd2, 4'd2);
        run_one_read(40);

        // Directed table at one-tick waits, a zero sample delay and a zero byte count
        apply_timing(16'd1, 8'd0 + 8'd1, 8'd1, 8'd0, 4'd0);
        for (r = 0; r < 39; r++)
            send_sample(DIRECTED_ROWS[r].st, DIRECTED_ROWS[r].tk, DIRECTED_ROWS[r].lv,
                        DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        // One read with a one-tick start pulse, other waits zero, byte count above range
        apply_timing(16'd1, 8'd0, 8'd0, 8'd0, 4'hF);
        run_one_read(-1);

        // Random reads under each idling pattern
        for (ph = 0; ph < 4; ph++)
        begin
            src_idle_pct   = SRC_IDLE[ph];
            sink_stall_pct = SINK_STALL[ph];
            tick_pct       = 100;
            noise_pct      = 0;
            apply_timing(16'($urandom_range(1, 12)), 8'($urandom_range(1, 5)),
                         8'($urandom_range(1, 5)), 8'($urandom_range(1, 4)),
                         4'(READ_LEN[ph]));
            tick_pct  = 85;
            noise_pct = 10;
            repeat (RANDOM_STEPS) sensor_step();
            finish_read();
        end

        // Drain and settle
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
src/swsr_pkg.sv
src/single_wire_sensor_reader.sv
tb/tb_top.sv
